// ----- sv/tpi_pkg.sv -----
// Shared constants and types for the timestamped pose interpolator.
// Holds the history depth, derived widths, the history row layout and the codes.
// Depends on nothing.
package tpi_pkg;

	// Number of history rows held in the pose store.
	localparam int HISTORY_DEPTH = 64;
	localparam int AW            = $clog2(HISTORY_DEPTH);
	localparam int CW            = $clog2(HISTORY_DEPTH + 1);

	// Fraction width of the divider and the number of steps it takes.
	localparam int FRAC_W    = 48;
	localparam int DIV_STEPS = 48;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Configuration port address width.
	localparam int ADDR_W = 4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_CAPACITY  = 2'd0;
	localparam logic [1:0] REG_EXT_EN    = 2'd1;
	localparam logic [1:0] REG_EXT_LIMIT = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	// One row of the pose history.
	typedef struct packed {
		logic [31:0]       stamp;
		logic [5:0][31:0]  pos;
		logic [2:0][15:0]  ang;
	} entry_t;

endpackage

// ----- sv/timestamped_pose_interpolator_core.sv -----
// Timestamped pose history with linear interpolation, single module.
// Holds the history memory, the search and shift sequencer, the divider and the blend unit.
// Depends on tpi_pkg.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   func, stamp, pose fields
// out       output     out_valid/out_stall res_* fields, status
// cfg       input      APB psel/penable    capacity, extrapolate_enable, extrapolation_limit
//
// A push runs the binary search, then evicts the oldest rows as needed and moves newer rows
// up for the sorted insert, each one read from memory and written back one place higher.
// A query runs the binary search and the bit-serial divider, then blends one field at a time
// through the shared multiplier.
// Reset empties the history at once; no clearing pass is needed.
// in_stall is high whenever the sequencer is busy; a waiting result does not hold up pushes.
module timestamped_pose_interpolator_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [31:0]               stamp,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [31:0]        pos_z,
	input  logic signed [31:0]        off_x,
	input  logic signed [31:0]        off_y,
	input  logic signed [31:0]        off_z,
	input  logic signed [15:0]        heading,
	input  logic signed [15:0]        tilt,
	input  logic signed [15:0]        bank,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        res_x,
	output logic signed [31:0]        res_y,
	output logic signed [31:0]        res_z,
	output logic signed [31:0]        res_off_x,
	output logic signed [31:0]        res_off_y,
	output logic signed [31:0]        res_off_z,
	output logic signed [15:0]        res_heading,
	output logic signed [15:0]        res_tilt,
	output logic signed [15:0]        res_bank,
	output logic [1:0]                status,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tpi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import tpi_pkg::*;

	localparam logic [4:0] ST_IDLE       = 5'd0;
	localparam logic [4:0] ST_S_RD       = 5'd1;
	localparam logic [4:0] ST_S_CMP      = 5'd2;
	localparam logic [4:0] ST_P_DUP_RD   = 5'd3;
	localparam logic [4:0] ST_P_DUP_CHK  = 5'd4;
	localparam logic [4:0] ST_P_EVICT    = 5'd5;
	localparam logic [4:0] ST_P_SHIFT_RD = 5'd6;
	localparam logic [4:0] ST_P_SHIFT_WR = 5'd7;
	localparam logic [4:0] ST_P_INS      = 5'd8;
	localparam logic [4:0] ST_Q_CASE     = 5'd9;
	localparam logic [4:0] ST_Q_RD_B     = 5'd10;
	localparam logic [4:0] ST_Q_RD_A     = 5'd11;
	localparam logic [4:0] ST_Q_LAT_A    = 5'd12;
	localparam logic [4:0] ST_Q_CHK      = 5'd13;
	localparam logic [4:0] ST_Q_DIV      = 5'd14;
	localparam logic [4:0] ST_F_PREP     = 5'd15;
	localparam logic [4:0] ST_F_MHI      = 5'd16;
	localparam logic [4:0] ST_F_MLO      = 5'd17;
	localparam logic [4:0] ST_F_SUM      = 5'd18;
	localparam logic [4:0] ST_F_FIN      = 5'd19;
	localparam logic [4:0] ST_Q_DONE     = 5'd20;

	localparam logic [CW-1:0] ONE_C = CW'(1);

	// Maps a sorted position onto the ring that holds the history.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(idx);
		if (sum >= (CW+1)'(HISTORY_DEPTH)) begin
			sum = sum - (CW+1)'(HISTORY_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [4:0]            state_q;
	logic                  func_q;
	entry_t                in_row_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [6:0]            cap_q;
	logic                  ext_en_q;
	logic [31:0]           limit_q;
	logic [CW-1:0]         lo_q, hi_q, mid_q, j_q, b_q, a_q;
	logic                  interp_q, single_q, before_q;
	entry_t                row_b_q, row_a_q, rdata_q;
	entry_t                mem [HISTORY_DEPTH];
	logic [31:0]           rem_q, den_q;
	logic [FRAC_W-1:0]     dvd_q, quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [3:0]            k_q;
	logic                  neg_q, ovf_q;
	logic [31:0]           mag_q, ahi_q;
	logic signed [31:0]    p1_q;
	logic [55:0]           prod_q;
	logic [41:0]           delta_q;
	logic [5:0][31:0]      res_pos_q, out_pos_q;
	logic [2:0][15:0]      res_ang_q, out_ang_q;
	logic [1:0]            res_st_q, out_st_q;
	logic                  out_valid_q;

	// Effective capacity: zero acts as one, and the store depth bounds it.
	logic [CW-1:0] cap_eff;
	always_comb begin
		if (cap_q == 7'd0) begin
			cap_eff = ONE_C;
		end else if (32'(cap_q) > 32'(HISTORY_DEPTH)) begin
			cap_eff = CW'(HISTORY_DEPTH);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	// Binary search midpoint.
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_w;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[CW:1];

	// Memory address and write selection per sequencer state.
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	entry_t        wr_data;
	always_comb begin
		rd_addr = '0;
		wr_addr = '0;
		wr_en   = 1'b0;
		wr_data = in_row_q;
		unique case (state_q)
			ST_S_RD:       rd_addr = phys(head_q, mid_w);
			ST_P_DUP_RD:   rd_addr = phys(head_q, lo_q);
			ST_P_SHIFT_RD: rd_addr = phys(head_q, j_q - ONE_C);
			ST_Q_RD_B:     rd_addr = phys(head_q, b_q);
			ST_Q_RD_A:     rd_addr = phys(head_q, a_q);
			ST_P_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, j_q);
				wr_data = rdata_q;
			end
			ST_P_INS: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, lo_q);
			end
			default: ;
		endcase
	end

	// History memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Distances used for the outside-range decision.
	logic [31:0] dist_w, gap_w;
	always_comb begin
		dist_w = (in_row_q.stamp > row_b_q.stamp) ? in_row_q.stamp - row_b_q.stamp
			: row_b_q.stamp - in_row_q.stamp;
		gap_w  = (row_b_q.stamp > row_a_q.stamp) ? row_b_q.stamp - row_a_q.stamp
			: row_a_q.stamp - row_b_q.stamp;
	end

	// One divider step: shift in a dividend bit and subtract when it fits.
	logic [32:0] rem_sh;
	logic        div_ge;
	logic [32:0] rem_sub;
	assign rem_sh  = {rem_q, dvd_q[FRAC_W-1]};
	assign div_ge  = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Field operands and their difference; an interpolated heading takes the short way round.
	logic [1:0]         ang_i;
	logic signed [33:0] p1_w, p2_w, d_w;
	logic [31:0]        mag_w;
	always_comb begin
		ang_i = 2'(k_q - 4'd6);
		if (k_q < 4'd6) begin
			p1_w = 34'($signed(row_b_q.pos[k_q[2:0]]));
			p2_w = 34'($signed(row_a_q.pos[k_q[2:0]]));
		end else begin
			p1_w = 34'($signed(row_b_q.ang[ang_i]));
			p2_w = 34'($signed(row_a_q.ang[ang_i]));
		end
		d_w = interp_q ? p2_w - p1_w : p1_w - p2_w;
		if (k_q == 4'd6 && interp_q) begin
			if (d_w > 34'sd32768) begin
				d_w = d_w - 34'sd65536;
			end else if (d_w < -34'sd32768) begin
				d_w = d_w + 34'sd65536;
			end
		end
		mag_w = (d_w < 0) ? 32'(-d_w) : 32'(d_w);
	end

	// The shared multiplier: magnitude times one half of the fraction.
	logic [23:0] mul_b;
	logic [55:0] mul_out;
	assign mul_b   = (state_q == ST_F_MHI) ? quo_q[47:24] : quo_q[23:0];
	assign mul_out = {24'd0, mag_q} * {32'd0, mul_b};

	// Rounded low product and the scaled delta.
	logic [55:0] lo_round;
	logic [41:0] delta_w;
	assign lo_round = prod_q + 56'd32768;
	assign delta_w  = ovf_q ? (42'd1 << 40) : ({2'd0, ahi_q, 8'd0} + {2'd0, lo_round[55:16]});

	// Apply the delta and saturate to the field width; the heading wraps instead.
	logic signed [43:0] v_w;
	logic [31:0]        sat32_w;
	logic [15:0]        sat16_w, hd_w;
	always_comb begin
		v_w = neg_q ? 44'($signed(p1_q)) - $signed({2'd0, delta_q})
			: 44'($signed(p1_q)) + $signed({2'd0, delta_q});
		if (v_w > 44'sd2147483647) begin
			sat32_w = 32'h7FFF_FFFF;
		end else if (v_w < -44'sd2147483648) begin
			sat32_w = 32'h8000_0000;
		end else begin
			sat32_w = v_w[31:0];
		end
		if (v_w > 44'sd32767) begin
			sat16_w = 16'h7FFF;
		end else if (v_w < -44'sd32768) begin
			sat16_w = 16'h8000;
		end else begin
			sat16_w = v_w[15:0];
		end
		hd_w = interp_q ? v_w[15:0] : p1_q[15:0];
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= 1'b0;
			in_row_q    <= '0;
			head_q      <= '0;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			j_q         <= '0;
			b_q         <= '0;
			a_q         <= '0;
			interp_q    <= 1'b0;
			single_q    <= 1'b0;
			before_q    <= 1'b0;
			row_b_q     <= '0;
			row_a_q     <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			dvd_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			k_q         <= '0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			mag_q       <= '0;
			ahi_q       <= '0;
			p1_q        <= '0;
			prod_q      <= '0;
			delta_q     <= '0;
			res_pos_q   <= '0;
			res_ang_q   <= '0;
			res_st_q    <= ST_OK;
			out_pos_q   <= '0;
			out_ang_q   <= '0;
			out_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result frees the output register unless a new one is loaded.
			if (out_valid_q && !out_stall && state_q != ST_Q_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q    <= func;
						in_row_q  <= {stamp, off_z, off_y, off_x, pos_z, pos_y, pos_x,
							bank, tilt, heading};
						lo_q      <= '0;
						hi_q      <= count_q;
						state_q   <= ST_S_RD;
					end
				end
				// Binary search for the first row not older than the request.
				ST_S_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w;
						state_q <= ST_S_CMP;
					end else begin
						state_q <= func_q ? ST_Q_CASE : ST_P_DUP_RD;
					end
				end
				ST_S_CMP: begin
					if (rdata_q.stamp < in_row_q.stamp) begin
						lo_q <= mid_q + ONE_C;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_S_RD;
				end
				// A push with a stamp already held is dropped.
				ST_P_DUP_RD: begin
					state_q <= (lo_q < count_q) ? ST_P_DUP_CHK : ST_P_EVICT;
				end
				ST_P_DUP_CHK: begin
					state_q <= (rdata_q.stamp == in_row_q.stamp) ? ST_IDLE : ST_P_EVICT;
				end
				// Drop the oldest rows until one slot is free.
				ST_P_EVICT: begin
					if (count_q >= cap_eff && count_q != '0) begin
						head_q  <= phys(head_q, ONE_C);
						count_q <= count_q - ONE_C;
						if (lo_q != '0) begin
							lo_q <= lo_q - ONE_C;
						end
					end else if (lo_q < count_q) begin
						j_q     <= count_q;
						state_q <= ST_P_SHIFT_RD;
					end else begin
						state_q <= ST_P_INS;
					end
				end
				// Move newer rows up one place, newest first.
				ST_P_SHIFT_RD: begin
					state_q <= ST_P_SHIFT_WR;
				end
				ST_P_SHIFT_WR: begin
					j_q     <= j_q - ONE_C;
					state_q <= ((j_q - ONE_C) > lo_q) ? ST_P_SHIFT_RD : ST_P_INS;
				end
				ST_P_INS: begin
					count_q <= count_q + ONE_C;
					state_q <= ST_IDLE;
				end
				// Pick the two rows that a query blends.
				ST_Q_CASE: begin
					interp_q <= 1'b0;
					single_q <= 1'b0;
					before_q <= (lo_q == '0);
					if (count_q == '0) begin
						res_pos_q <= '0;
						res_ang_q <= '0;
						res_st_q  <= ST_EMPTY;
						state_q   <= ST_Q_DONE;
					end else begin
						if (count_q == ONE_C) begin
							b_q      <= '0;
							a_q      <= '0;
							single_q <= 1'b1;
						end else if (lo_q != '0 && lo_q < count_q) begin
							b_q      <= lo_q - ONE_C;
							a_q      <= lo_q;
							interp_q <= 1'b1;
						end else if (lo_q == '0) begin
							b_q <= '0;
							a_q <= ONE_C;
						end else begin
							b_q <= count_q - ONE_C;
							a_q <= count_q - CW'(2);
						end
						state_q <= ST_Q_RD_B;
					end
				end
				ST_Q_RD_B: begin
					state_q <= ST_Q_RD_A;
				end
				ST_Q_RD_A: begin
					row_b_q <= rdata_q;
					state_q <= ST_Q_LAT_A;
				end
				ST_Q_LAT_A: begin
					row_a_q <= rdata_q;
					state_q <= ST_Q_CHK;
				end
				// Decide between a held row, a limit report and the divider.
				ST_Q_CHK: begin
					res_pos_q <= row_b_q.pos;
					res_ang_q <= row_b_q.ang;
					res_st_q  <= ST_OK;
					rem_q     <= '0;
					quo_q     <= '0;
					step_q    <= '0;
					if (single_q) begin
						state_q <= ST_Q_DONE;
					end else if (interp_q) begin
						dvd_q   <= {in_row_q.stamp - row_b_q.stamp, 16'd0};
						den_q   <= row_a_q.stamp - row_b_q.stamp;
						state_q <= ST_Q_DIV;
					end else if (before_q && row_b_q.stamp == in_row_q.stamp) begin
						state_q <= ST_Q_DONE;
					end else if (!ext_en_q) begin
						state_q <= ST_Q_DONE;
					end else if (dist_w > limit_q || gap_w == '0) begin
						res_st_q <= ST_LIMIT;
						state_q  <= ST_Q_DONE;
					end else begin
						dvd_q   <= {dist_w, 16'd0};
						den_q   <= gap_w;
						state_q <= ST_Q_DIV;
					end
				end
				// Restoring division, one quotient bit a cycle.
				ST_Q_DIV: begin
					rem_q  <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
					quo_q  <= {quo_q[FRAC_W-2:0], div_ge};
					dvd_q  <= {dvd_q[FRAC_W-2:0], 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						k_q     <= '0;
						state_q <= ST_F_PREP;
					end
				end
				// Blend one field at a time through the shared multiplier.
				ST_F_PREP: begin
					p1_q    <= p1_w[31:0];
					neg_q   <= d_w < 0;
					mag_q   <= mag_w;
					state_q <= ST_F_MHI;
				end
				ST_F_MHI: begin
					prod_q  <= mul_out;
					state_q <= ST_F_MLO;
				end
				ST_F_MLO: begin
					ahi_q   <= prod_q[31:0];
					ovf_q   <= prod_q[55:32] != '0;
					prod_q  <= mul_out;
					state_q <= ST_F_SUM;
				end
				ST_F_SUM: begin
					delta_q <= delta_w;
					state_q <= ST_F_FIN;
				end
				ST_F_FIN: begin
					if (k_q < 4'd6) begin
						res_pos_q[k_q[2:0]] <= sat32_w;
					end else if (k_q == 4'd6) begin
						res_ang_q[0] <= hd_w;
					end else begin
						res_ang_q[ang_i] <= sat16_w;
					end
					if (k_q == 4'd8) begin
						state_q <= ST_Q_DONE;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ST_F_PREP;
					end
				end
				// Hand the result to the output register once it is free.
				ST_Q_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_pos_q   <= res_pos_q;
						out_ang_q   <= res_ang_q;
						out_st_q    <= res_st_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= 7'd64;
			ext_en_q <= 1'b0;
			limit_q  <= 32'd100000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_CAPACITY:  cap_q    <= pwdata[6:0];
				REG_EXT_EN:    ext_en_q <= pwdata[0];
				REG_EXT_LIMIT: limit_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			REG_CAPACITY:  prdata = {25'd0, cap_q};
			REG_EXT_EN:    prdata = {31'd0, ext_en_q};
			REG_EXT_LIMIT: prdata = limit_q;
			default:       prdata = '0;
		endcase
	end

	assign pready      = 1'b1;
	assign in_stall    = state_q != ST_IDLE;
	assign out_valid   = out_valid_q;
	assign res_x       = out_pos_q[0];
	assign res_y       = out_pos_q[1];
	assign res_z       = out_pos_q[2];
	assign res_off_x   = out_pos_q[3];
	assign res_off_y   = out_pos_q[4];
	assign res_off_z   = out_pos_q[5];
	assign res_heading = out_ang_q[0];
	assign res_tilt    = out_ang_q[1];
	assign res_bank    = out_ang_q[2];
	assign status      = out_st_q;

`ifndef SYNTHESIS
	// The history never holds more rows than the store has.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HISTORY_DEPTH))
		else $error("history count beyond store depth");

	// A result appears only when the sequencer hands one over.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_Q_DONE))
		else $error("result raised outside the hand-over state");

	// An insert grows the history by exactly one row.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_INS) |=> count_q == $past(count_q) + ONE_C)
		else $error("insert did not add one row");
`endif

endmodule

// ----- dv/tb_timestamped_pose_interpolator_core.sv -----
// Self-checking testbench for the timestamped pose interpolator core.
// Drives push and query requests, predicts each result and compares it field by field.
// Depends on tpi_pkg and timestamped_pose_interpolator_core.
module tb_timestamped_pose_interpolator_core;
	import tpi_pkg::*;

	localparam int  DEPTH_M     = 64;
	localparam int  RANDOM_REQS = 1850;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct {
		logic              fn;
		logic [31:0]       ts;
		logic signed [31:0] p [6];
		logic signed [15:0] a [3];
	} pose_req_t;

	typedef struct {
		logic [31:0] p [6];
		logic [15:0] a [3];
		logic [1:0]  st;
	} pose_res_t;

	typedef struct {
		logic              fn;
		logic [31:0]       ts;
		logic signed [31:0] p0;
		logic signed [15:0] a0;
		bit                typed;
		logic [1:0]        st_exp;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, func;
	logic [31:0] stamp;
	logic signed [31:0] pos_x, pos_y, pos_z, off_x, off_y, off_z;
	logic signed [15:0] heading, tilt, bank;
	logic out_valid, out_stall;
	logic signed [31:0] res_x, res_y, res_z, res_off_x, res_off_y, res_off_z;
	logic signed [15:0] res_heading, res_tilt, res_bank;
	logic [1:0] status;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	// Predictor state.
	logic [31:0]        hist_time [DEPTH_M];
	logic signed [31:0] hist_pos  [DEPTH_M][6];
	logic signed [15:0] hist_ang  [DEPTH_M][3];
	int unsigned        hist_count;
	logic [6:0]         cfg_cap;
	logic               cfg_ext;
	logic [31:0]        cfg_limit;

	pose_res_t pending_poses[$];
	int        error_count = 0;
	longint    cycle_count = 0;
	bit        hold_recv;
	bit        idle_free;

	timestamped_pose_interpolator_core dut (.*);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	function automatic int unsigned cap_eff();
		if (cfg_cap == 0) return 1;
		if (cfg_cap > DEPTH_M) return DEPTH_M;
		return cfg_cap;
	endfunction

	function automatic int unsigned find_slot(logic [31:0] t);
		int unsigned i;
		i = 0;
		while (i < hist_count && hist_time[i] < t) i++;
		return i;
	endfunction

	// Rounded magnitude scaling with the same cap as the block.
	function automatic logic [63:0] scale_mag(logic [63:0] mag, logic [63:0] frac);
		logic [63:0] hi, lo, prod;
		hi = frac >> 24;
		lo = frac & 64'hFFFFFF;
		prod = mag * hi;
		if (prod >= 64'h1_0000_0000) return 64'h1 << 40;
		return (prod << 8) + ((mag * lo + 64'd32768) >> 16);
	endfunction

	function automatic longint mix_step(longint p1, longint d, logic [63:0] frac);
		logic [63:0] mag;
		longint delta;
		mag = d < 0 ? 64'(-d) : 64'(d);
		delta = longint'(scale_mag(mag, frac));
		return d < 0 ? p1 - delta : p1 + delta;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic pose_res_t take_entry(int unsigned i, logic [1:0] st);
		pose_res_t r;
		for (int k = 0; k < 6; k++) r.p[k] = hist_pos[i][k];
		for (int k = 0; k < 3; k++) r.a[k] = hist_ang[i][k];
		r.st = st;
		return r;
	endfunction

	task automatic store_pose(input pose_req_t q);
		int unsigned slot;
		slot = find_slot(q.ts);
		if (slot < hist_count && hist_time[slot] == q.ts) return;
		// Evict oldest rows until one is free.
		while (hist_count >= cap_eff() && hist_count > 0) begin
			for (int i = 0; i + 1 < hist_count; i++) begin
				hist_time[i] = hist_time[i + 1];
				hist_pos[i] = hist_pos[i + 1];
				hist_ang[i] = hist_ang[i + 1];
			end
			hist_count--;
		end
		slot = find_slot(q.ts);
		for (int i = hist_count; i > slot; i--) begin
			hist_time[i] = hist_time[i - 1];
			hist_pos[i] = hist_pos[i - 1];
			hist_ang[i] = hist_ang[i - 1];
		end
		hist_time[slot] = q.ts;
		for (int k = 0; k < 6; k++) hist_pos[slot][k] = q.p[k];
		for (int k = 0; k < 3; k++) hist_ang[slot][k] = q.a[k];
		hist_count++;
	endtask

	function automatic pose_res_t lookup_pose(logic [31:0] t);
		pose_res_t r;
		int unsigned p, b, a;
		logic [63:0] frac;
		logic [31:0] t1, t2, reach, gap;
		longint h1, d, v1, v2;
		if (hist_count == 0) begin
			for (int k = 0; k < 6; k++) r.p[k] = '0;
			for (int k = 0; k < 3; k++) r.a[k] = '0;
			r.st = ST_EMPTY;
			return r;
		end
		if (hist_count == 1) return take_entry(0, ST_OK);
		p = find_slot(t);
		if (p > 0 && p < hist_count) begin
			b = p - 1;
			t1 = hist_time[b];
			t2 = hist_time[p];
			frac = (64'(t - t1) << 16) / 64'(t2 - t1);
			for (int k = 0; k < 6; k++) begin
				v1 = hist_pos[b][k];
				v2 = hist_pos[p][k];
				r.p[k] = 32'(clip(mix_step(v1, v2 - v1, frac), 32));
			end
			h1 = hist_ang[b][0];
			d = longint'(hist_ang[p][0]) - h1;
			if (d > 32768) d -= 65536;
			else if (d < -32768) d += 65536;
			r.a[0] = 16'(mix_step(h1, d, frac));
			for (int k = 1; k < 3; k++) begin
				v1 = hist_ang[b][k];
				v2 = hist_ang[p][k];
				r.a[k] = 16'(clip(mix_step(v1, v2 - v1, frac), 16));
			end
			r.st = ST_OK;
			return r;
		end
		if (p == 0 && hist_time[0] == t) return take_entry(0, ST_OK);
		if (p == 0) begin
			b = 0;
			a = 1;
		end else begin
			b = hist_count - 1;
			a = hist_count - 2;
		end
		if (!cfg_ext) return take_entry(b, ST_OK);
		t1 = hist_time[b];
		t2 = hist_time[a];
		reach = t > t1 ? t - t1 : t1 - t;
		gap = t1 > t2 ? t1 - t2 : t2 - t1;
		if (reach > cfg_limit || gap == 0) return take_entry(b, ST_LIMIT);
		frac = (64'(reach) << 16) / 64'(gap);
		for (int k = 0; k < 6; k++) begin
			v1 = hist_pos[b][k];
			v2 = hist_pos[a][k];
			r.p[k] = 32'(clip(mix_step(v1, v1 - v2, frac), 32));
		end
		r.a[0] = hist_ang[b][0];
		for (int k = 1; k < 3; k++) begin
			v1 = hist_ang[b][k];
			v2 = hist_ang[a][k];
			r.a[k] = 16'(clip(mix_step(v1, v1 - v2, frac), 16));
		end
		r.st = ST_OK;
		return r;
	endfunction

	// Random idle decision, about 29 in a hundred outside quiet stretches.
	function automatic bit idle_now();
		return !idle_free && ($urandom_range(99) < 29);
	endfunction

	// Single APB write: setup then access phase.
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CAPACITY:  cfg_cap = val[6:0];
			REG_EXT_EN:    cfg_ext = val[0];
			REG_EXT_LIMIT: cfg_limit = val;
			default: ;
		endcase
	endtask

	// Wait until every result has come, then let the block settle.
	task automatic drain();
		int guard;
		guard = 0;
		while (pending_poses.size() != 0) @(posedge clk);
		while (guard < 200) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Offer one request at a falling edge and hold it until accepted.
	task automatic send_req(input pose_req_t q);
		@(negedge clk);
		while (idle_now()) @(negedge clk);
		in_valid <= 1'b1;
		func <= q.fn;
		stamp <= q.ts;
		pos_x <= q.p[0];
		pos_y <= q.p[1];
		pos_z <= q.p[2];
		off_x <= q.p[3];
		off_y <= q.p[4];
		off_z <= q.p[5];
		heading <= q.a[0];
		tilt <= q.a[1];
		bank <= q.a[2];
		do @(posedge clk); while (in_stall);
		if (q.fn == FUNC_PUSH) store_pose(q);
		else pending_poses.push_back(lookup_pose(q.ts));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic pose_req_t rand_pose(logic fn, logic [31:0] ts);
		pose_req_t q;
		q.fn = fn;
		q.ts = ts;
		for (int k = 0; k < 6; k++) begin
			case ($urandom_range(3))
				0: q.p[k] = $urandom;
				1: q.p[k] = $urandom_range(2000) - 1000;
				2: q.p[k] = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
				default: q.p[k] = $urandom_range(2000000) - 1000000;
			endcase
		end
		for (int k = 0; k < 3; k++) q.a[k] = 16'($urandom);
		return q;
	endfunction

	// Result side: random stall, checking at each accepted result.
	initial begin
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			out_stall <= hold_recv || idle_now();
		end
	end

	always @(posedge clk) begin
		pose_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected result", 32'(status), 32'(0));
			end else begin
				w = pending_poses.pop_front();
				if (res_x !== w.p[0]) report_mismatch("res_x", res_x, w.p[0]);
				if (res_y !== w.p[1]) report_mismatch("res_y", res_y, w.p[1]);
				if (res_z !== w.p[2]) report_mismatch("res_z", res_z, w.p[2]);
				if (res_off_x !== w.p[3]) report_mismatch("res_off_x", res_off_x, w.p[3]);
				if (res_off_y !== w.p[4]) report_mismatch("res_off_y", res_off_y, w.p[4]);
				if (res_off_z !== w.p[5]) report_mismatch("res_off_z", res_off_z, w.p[5]);
				if (res_heading !== w.a[0])
					report_mismatch("res_heading", 32'(res_heading), 32'(w.a[0]));
				if (res_tilt !== w.a[1]) report_mismatch("res_tilt", 32'(res_tilt), 32'(w.a[1]));
				if (res_bank !== w.a[2]) report_mismatch("res_bank", 32'(res_bank), 32'(w.a[2]));
				if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
			end
		end
	end

	// Main stimulus.
	initial begin
		dir_row_t rows[$];
		pose_req_t q;
		pose_res_t w;
		logic [31:0] base;
		int n, hold;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_PUSH;
		stamp = '0;
		{pos_x, pos_y, pos_z, off_x, off_y, off_z} = '0;
		{heading, tilt, bank} = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hist_count = 0;
		cfg_cap = 7'd64;
		cfg_ext = 1'b0;
		cfg_limit = 32'd100000;
		hold_recv = 1'b0;
		idle_free = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty, extremes, duplicates, half-turn wrap, exact stamps.
		rows = '{
			'{FUNC_QUERY, 32'd0, 32'sd0, 16'sd0, 1'b1, ST_EMPTY},
			'{FUNC_QUERY, 32'hFFFFFFFF, 32'sd0, 16'sd0, 1'b1, ST_EMPTY},
			'{FUNC_PUSH, 32'd1000, 32'sh7FFFFFFF, 16'sh7FFF, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd5, 32'sd0, 16'sd0, 1'b1, ST_OK},
			'{FUNC_PUSH, 32'd1000, 32'sd5, 16'sd5, 1'b0, ST_OK},
			'{FUNC_PUSH, 32'd3000, 32'sh80000000, -16'sh8000, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd1000, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd2000, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd3000, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd0, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'hFFFFFFFF, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_PUSH, 32'd0, 32'sd100, 16'sd16384, 1'b0, ST_OK},
			'{FUNC_PUSH, 32'hFFFFFFFF, -32'sd100, -16'sd16384, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd500, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'h80000000, 32'sd0, 16'sd0, 1'b0, ST_OK},
			'{FUNC_QUERY, 32'd1, 32'sd0, 16'sd0, 1'b0, ST_OK}
		};
		foreach (rows[i]) begin
			q.fn = rows[i].fn;
			q.ts = rows[i].ts;
			for (int k = 0; k < 6; k++) q.p[k] = rows[i].p0 + 32'(k);
			for (int k = 0; k < 3; k++) q.a[k] = rows[i].a0;
			n = pending_poses.size();
			send_req(q);
			if (rows[i].typed && pending_poses.size() > n) begin
				w = pending_poses[$];
				if (w.st !== rows[i].st_exp)
					report_mismatch("table status", 32'(w.st), 32'(rows[i].st_exp));
			end
		end
		drain();

		// Extrapolation settings and limit extremes, with short histories.
		apb_write(REG_EXT_EN, 32'd1);
		apb_write(REG_EXT_LIMIT, 32'd0);
		q = rand_pose(FUNC_QUERY, 32'd10);
		send_req(q);
		q = rand_pose(FUNC_QUERY, 32'd0);
		send_req(q);
		drain();
		apb_write(REG_EXT_LIMIT, 32'hFFFFFFFF);
		q = rand_pose(FUNC_QUERY, 32'd10);
		send_req(q);
		drain();
		apb_write(REG_CAPACITY, 32'd0);
		q = rand_pose(FUNC_PUSH, 32'd77);
		send_req(q);
		q = rand_pose(FUNC_QUERY, 32'd90);
		send_req(q);
		drain();

		// Random phases: stamps mostly rising around a moving base, some older or jumping.
		base = $urandom;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: apb_write(REG_CAPACITY, 32'($urandom_range(127)));
				1: apb_write(REG_CAPACITY, 32'd1);
				2: apb_write(REG_CAPACITY, 32'd64);
				default: apb_write(REG_CAPACITY, 32'($urandom_range(2, 8)));
			endcase
			apb_write(REG_EXT_EN, 32'($urandom_range(1)));
			apb_write(REG_EXT_LIMIT, ph == 7 ? 32'hFFFFFFFF : 32'($urandom_range(200000)));
			idle_free = (ph == 3);
			for (int i = 0; i < RANDOM_REQS / 8; i++) begin
				if ($urandom_range(9) < 5) begin
					base = base + 32'($urandom_range(5000));
					if ($urandom_range(19) == 0) base = $urandom;
					q = rand_pose(FUNC_PUSH, $urandom_range(9) == 0 ? base - 32'($urandom_range(50)) : base);
				end else begin
					q = rand_pose(FUNC_QUERY, base - 32'($urandom_range(30000))
						+ 32'($urandom_range(20000)));
					if ($urandom_range(29) == 0) q.ts = $urandom;
				end
				send_req(q);
				// Receiver holds off while the sender keeps offering.
				if (ph == 5 && i == 20) begin
					fork
						begin
							hold_recv = 1'b1;
							hold = 0;
							while (hold < 2000) begin
								@(posedge clk);
								hold++;
							end
							hold_recv = 1'b0;
						end
					join_none
				end
				// Sender pauses until everything is back.
				if (ph == 6 && i == 50) while (pending_poses.size() != 0) @(posedge clk);
			end
			drain();
		end
		drain();
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
